// ===== hw/rtl/qhpq_pkg.sv =====
// qhpq_pkg: shared types and codes for the quaternary heap priority queue
// no dependencies
`timescale 1ns / 1ps
package qhpq_pkg;

  localparam int unsigned ElemW    = 32;
  localparam int unsigned PrioW    = 32;
  localparam int unsigned HeldW    = 9;
  localparam int unsigned Arity    = 4;
  localparam int unsigned ArityLg2 = 2;

  localparam logic [1:0] OpEnqueue = 2'd0;
  localparam logic [1:0] OpDequeue = 2'd1;
  localparam logic [1:0] OpPeek    = 2'd2;
  localparam logic [1:0] OpClear   = 2'd3;

  localparam logic [1:0] StatOk    = 2'd0;
  localparam logic [1:0] StatEmpty = 2'd1;
  localparam logic [1:0] StatFull  = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [ElemW-1:0] element_in;
    logic [PrioW-1:0] priority_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [ElemW-1:0] element_out;
    logic [PrioW-1:0] priority_out;
    logic [HeldW-1:0] entries_held;
  } rsp_t;

endpackage

// ===== hw/rtl/qhpq_cmp.sv =====
// qhpq_cmp: shared priority comparator, true when a goes strictly before b
// depends on nothing but its parameter
`timescale 1ns / 1ps
module qhpq_cmp #(
  parameter int unsigned PRIORITY_BITS = 32
) (
  input  logic                     max_first_i,
  input  logic [PRIORITY_BITS-1:0] a_i,
  input  logic [PRIORITY_BITS-1:0] b_i,
  output logic                     first_o
);
  // one magnitude compare, direction picked by the order register
  assign first_o = max_first_i ? (a_i > b_i) : (a_i < b_i);
endmodule

// ===== hw/rtl/quaternary_heap_priority_queue_top.sv =====
// quaternary_heap_priority_queue_top: heap store, sift sequencer, apb register
// depends on qhpq_pkg and qhpq_cmp
`timescale 1ns / 1ps
// Priority queue kept as a 4-ary heap in one single-port memory with a
// registered read. busy is high from the accepting edge until the result
// strobe; done_o is high for one cycle and cannot be stalled, and the next
// item can be accepted in that same cycle; result_o holds the result until
// the next command is dispatched. Every memory access and every priority
// compare goes through one port and one comparator, one per cycle, so the
// time is set by the heap levels walked. Clear, enqueue into a full queue
// and dequeue or peek of an empty queue answer without using the memory;
// peek and a dequeue that empties the queue fetch only the root; enqueue
// reads and compares one parent per level climbed; dequeue reads the last
// entry into the root hole, then per node examined compares every child and
// the best child against it. Entries are always written before they are
// read, so no reset clearing pass is needed.
module quaternary_heap_priority_queue_top #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  qhpq_pkg::cmd_t       cmd_i,
  output logic                 done_o,
  output qhpq_pkg::rsp_t       result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [0:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import qhpq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = CW + ArityLg2 + 1;
  localparam int unsigned EW = PrioW + ElemW;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_UPRD, S_UPCMP, S_DNLAST, S_DNLOAD,
    S_CHSTART, S_CHCMP, S_DNCMP, S_RESP
  } state_e;

  state_e             state_q;
  logic               max_first_q;
  logic [CW-1:0]      count_q;
  cmd_t               cmd_q;
  logic [1:0]         stat_q;
  logic [EW-1:0]      root_q;    // output entry
  logic [EW-1:0]      cur_q;     // entry being sifted, kept out of the store
  logic [EW-1:0]      best_q;    // best child entry
  logic [CW-1:0]      pos_q;     // hole the sifted entry would fill
  logic [CW-1:0]      bidx_q;    // best child index
  logic [CW-1:0]      cidx_q;    // child scan index
  logic [CW-1:0]      cend_q;    // one past last child
  logic               bvalid_q;

  // heap memory, one port, registered read
  logic [EW-1:0] mem_q [CAPACITY];
  logic [EW-1:0] rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [EW-1:0] mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wdata;
    rdata_q <= mem_q[mem_addr];
  end

  // shared comparator, operands chosen by state
  logic [PrioW-1:0] cmp_a, cmp_b;
  logic             cmp_first;
  qhpq_cmp #(.PRIORITY_BITS(PrioW)) u_cmp (
    .max_first_i(max_first_q), .a_i(cmp_a), .b_i(cmp_b), .first_o(cmp_first)
  );

  // parent and child index arithmetic
  logic [CW-1:0] pos_m1;
  logic [CW-1:0] parent_idx;
  logic [IW-1:0] first_child;
  logic [IW-1:0] child_lim;
  logic [CW-1:0] child_end;
  logic [CW-1:0] cidx_p1;
  assign pos_m1      = pos_q - CW'(1);
  assign parent_idx  = pos_m1 >> ArityLg2;
  assign first_child = IW'({pos_q, {ArityLg2{1'b0}}}) + IW'(1);
  assign child_lim   = first_child + IW'(Arity);
  assign child_end   = (child_lim > IW'(count_q)) ? count_q : CW'(child_lim);
  assign cidx_p1     = cidx_q + CW'(1);

  always_comb begin
    cmp_a = cur_q[EW-1 -: PrioW];
    cmp_b = rdata_q[EW-1 -: PrioW];
    case (state_q)
      S_CHCMP: begin
        cmp_a = rdata_q[EW-1 -: PrioW];
        cmp_b = best_q[EW-1 -: PrioW];
      end
      S_DNCMP: begin
        cmp_a = best_q[EW-1 -: PrioW];
        cmp_b = cur_q[EW-1 -: PrioW];
      end
      default: ;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = '0;
    mem_wdata = cur_q;
    case (state_q)
      S_UPRD: begin
        // at the root the climbing entry lands, else fetch the parent
        if (pos_q == '0) mem_we = 1'b1;
        else mem_addr = AW'(parent_idx);
      end
      S_UPCMP: begin
        mem_we   = 1'b1;
        mem_addr = AW'(pos_q);
        if (cmp_first) mem_wdata = rdata_q;
      end
      S_DNLAST: mem_addr = AW'(count_q - CW'(1));
      S_CHSTART: begin
        // a leaf takes the entry, else fetch the first child
        if (first_child >= IW'(count_q)) begin
          mem_we   = 1'b1;
          mem_addr = AW'(pos_q);
        end else begin
          mem_addr = AW'(first_child);
        end
      end
      S_CHCMP: mem_addr = AW'(cidx_p1);
      S_DNCMP: begin
        mem_we   = 1'b1;
        mem_addr = AW'(pos_q);
        if (cmp_first) mem_wdata = best_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      max_first_q <= 1'b0;
      count_q     <= '0;
      cmd_q       <= '0;
      done_o      <= 1'b0;
      stat_q      <= StatOk;
      root_q      <= '0;
      cur_q       <= '0;
      best_q      <= '0;
      pos_q       <= '0;
      bidx_q      <= '0;
      cidx_q      <= '0;
      cend_q      <= '0;
      bvalid_q    <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (psel && penable && pwrite && paddr == 1'b0) max_first_q <= pwdata[0];
      case (state_q)
        S_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          root_q  <= '0;
          stat_q  <= StatOk;
          state_q <= S_RESP;
          case (cmd_q.operation)
            OpEnqueue: begin
              if (count_q >= CW'(CAPACITY)) stat_q <= StatFull;
              else begin
                pos_q   <= count_q;
                count_q <= count_q + CW'(1);
                cur_q   <= {cmd_q.priority_in, cmd_q.element_in};
                state_q <= S_UPRD;
              end
            end
            OpDequeue, OpPeek: begin
              if (count_q == '0) stat_q <= StatEmpty;
              else state_q <= S_DNLAST;
            end
            default: count_q <= '0;
          endcase
        end
        S_UPRD: state_q <= (pos_q == '0) ? S_RESP : S_UPCMP;
        S_UPCMP: begin
          // parent moves down into the hole, hole climbs
          if (cmp_first) begin
            pos_q   <= parent_idx;
            state_q <= S_UPRD;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_DNLAST: begin
          root_q <= rdata_q;
          if (cmd_q.operation == OpPeek) state_q <= S_RESP;
          else begin
            count_q <= count_q - CW'(1);
            state_q <= (count_q == CW'(1)) ? S_RESP : S_DNLOAD;
          end
        end
        S_DNLOAD: begin
          // last entry is sifted down from the root hole
          cur_q   <= rdata_q;
          pos_q   <= '0;
          state_q <= S_CHSTART;
        end
        S_CHSTART: begin
          if (first_child >= IW'(count_q)) state_q <= S_RESP;
          else begin
            cidx_q   <= CW'(first_child);
            cend_q   <= child_end;
            bvalid_q <= 1'b0;
            state_q  <= S_CHCMP;
          end
        end
        S_CHCMP: begin
          // keep the first strictly best child
          if (!bvalid_q || cmp_first) begin
            best_q <= rdata_q;
            bidx_q <= cidx_q;
          end
          bvalid_q <= 1'b1;
          cidx_q   <= cidx_p1;
          if (cidx_p1 == cend_q) state_q <= S_DNCMP;
        end
        S_DNCMP: begin
          // best child moves up into the hole, hole descends
          if (cmp_first) begin
            pos_q   <= bidx_q;
            state_q <= S_CHSTART;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          done_o  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy     = (state_q != S_IDLE);
  assign result_o = '{status:       stat_q,
                      element_out:  root_q[ElemW-1:0],
                      priority_out: root_q[EW-1 -: PrioW],
                      entries_held: HeldW'(count_q)};

  assign pready = 1'b1;
  assign prdata = {31'd0, max_first_q};
endmodule
